// ----- design/iufc_pkg.sv -----
// Shared types, constants and CRC helpers for the IuUP frame CRC checker.
// No dependencies; imported by every module of the block.
package iufc_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned COUNT_W  = 3;
	localparam int unsigned KIND_W   = 4;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned HCRC_W   = 6;
	localparam int unsigned PCRC_W   = 10;
	localparam int unsigned HDR_LEN  = 4;
	localparam int unsigned OUT_W    = 24;

	localparam logic [HCRC_W-1:0] POLY6_LOW = 6'h2f;   // D^6+D^5+D^3+D^2+D+1, top term dropped
	localparam logic [PCRC_W:0]   POLY10    = 11'h633; // D^10+D^9+D^5+D^4+D+1

	localparam logic [KIND_W-1:0] KIND_DATA = 4'd0;
	localparam logic [KIND_W-1:0] KIND_CTRL = 4'd14;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = 3'd7;
	localparam logic [COUNT_W-1:0] MIN_LEN       = 3'd4;
	localparam logic [COUNT_W-1:0] MIN_LEN_CTRL  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_DATA_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CTRL_OK    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_KIND   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_HDR_CRC    = 3'd5;
	localparam logic [STATUS_W-1:0] ST_PAYLD_CRC  = 3'd6;

	localparam logic CFG_WANT_DATA = 1'b0;
	localparam logic CFG_WANT_CTRL = 1'b1;

	// PDU state as seen after the current byte; header bytes beyond count read zero
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [BYTE_W-1:0]  h0;
		logic [BYTE_W-1:0]  h1;
		logic [BYTE_W-1:0]  h2;
		logic [BYTE_W-1:0]  h3;
		logic [PCRC_W-1:0]  acc;
	} pdu_snap_t;

	typedef struct packed {
		logic [PCRC_W-1:0]   pcrc;
		logic [HCRC_W-1:0]   hcrc;
		logic [KIND_W-1:0]   kind;
		logic [STATUS_W-1:0] status;
	} pdu_result_t;

	// Remainder of a 20-bit value modulo the CRC-10 polynomial (flat XOR network)
	function automatic logic [PCRC_W-1:0] crc10_mod(input logic [2*PCRC_W-1:0] v_in);
		logic [2*PCRC_W-1:0] v;
		v = v_in;
		for (int b = 2*PCRC_W-1; b >= PCRC_W; b--) begin
			if (v[b])
				v = v ^ ((2*PCRC_W)'(POLY10) << (b - PCRC_W));
		end
		return v[PCRC_W-1:0];
	endfunction

	// CRC-6 over two bytes, MSB first, zero start value
	function automatic logic [HCRC_W-1:0] crc6_of(input logic [BYTE_W-1:0] b0,
	                                             input logic [BYTE_W-1:0] b1);
		logic [2*BYTE_W-1:0] msg;
		logic [HCRC_W-1:0]   rem;
		logic                fb;
		msg = {b0, b1};
		rem = '0;
		for (int i = 2*BYTE_W-1; i >= 0; i--) begin
			fb  = rem[HCRC_W-1] ^ msg[i];
			rem = {rem[HCRC_W-2:0], 1'b0} ^ (fb ? POLY6_LOW : '0);
		end
		return rem;
	endfunction

endpackage

// ----- design/iuup_frame_crc_checker.sv -----
// Top level of the IuUP frame CRC checker: input register, tracker, evaluator,
// result register and configuration registers. Depends on iufc_pkg, iufc_track, iufc_judge.
//
//   channel   direction  transfer carries
//   s_*       in         one PDU byte (tdata) and end-of-PDU mark (tlast)
//   m_*       out        one result per PDU: status, kind, header CRC, payload CRC
//   cfg_*     in         register write: index 0 want_data, 1 want_ctrl
//
// One byte is taken per cycle while no held result stalls a last byte. A byte sits
// in the input register while the tracker and evaluator work on it, and the result
// register loads as the last byte leaves the input register; m_tvalid is its flag.
// A held result stalls the input register only when it carries another last byte.
// Reset clears the byte count, CRC accumulator and all valid flags; want_data and
// want_ctrl come up as 1. Writes to the configuration port are taken at any time.
module iuup_frame_crc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [iufc_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic                        s_tlast,   // last_byte
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [iufc_pkg::OUT_W-1:0]  m_tdata,   // [2:0] status, [6:3] pdu_kind,
	                                               // [12:7] computed_header_crc,
	                                               // [22:13] computed_payload_crc, [23] zero
	// configuration writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic                        cfg_data
);
	import iufc_pkg::*;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// result register
	logic        out_valid_q;
	pdu_result_t out_q;

	logic      want_data_q;
	logic      want_ctrl_q;
	logic      advance;
	pdu_snap_t snap;
	pdu_result_t res;

	// a byte moves on unless it closes a PDU and the result slot is still held
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	iufc_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.snap      (snap)
	);

	iufc_judge u_judge (
		.snap      (snap),
		.want_data (want_data_q),
		.want_ctrl (want_ctrl_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && last_s1)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.pcrc, out_q.hcrc, out_q.kind, out_q.status};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_data_q <= 1'b1;
			want_ctrl_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WANT_DATA: want_data_q <= cfg_data;
				CFG_WANT_CTRL: want_ctrl_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- design/iufc_track.sv -----
// Per-PDU byte tracker: byte count, header capture and running CRC-10.
// Depends on iufc_pkg.
module iufc_track (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [iufc_pkg::BYTE_W-1:0] data_byte,
	input  logic                     last_byte,
	output iufc_pkg::pdu_snap_t      snap
);
	import iufc_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [PCRC_W-1:0]  acc_q;
	logic [BYTE_W-1:0]  hdr_q [HDR_LEN];

	logic [COUNT_W-1:0] count_n;
	logic [PCRC_W-1:0]  acc_n;
	logic [BYTE_W-1:0]  hdr_n [HDR_LEN];
	logic               in_hdr;

	assign in_hdr = (count_q < COUNT_W'(HDR_LEN));

	always_comb begin
		count_n = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
		acc_n   = acc_q;
		if (!in_hdr)
			acc_n = {acc_q[1:0], 8'h00}
			        ^ crc10_mod({2'b00, acc_q[PCRC_W-1:2], 10'h000})
			        ^ {2'b00, data_byte};
		for (int i = 0; i < HDR_LEN; i++) begin
			if (in_hdr && count_q[1:0] == 2'(i))
				hdr_n[i] = data_byte;
			else if (count_q > COUNT_W'(i))
				hdr_n[i] = hdr_q[i];
			else
				hdr_n[i] = '0;   // not yet received in this PDU
		end
	end

	assign snap.count = count_n;
	assign snap.h0    = hdr_n[0];
	assign snap.h1    = hdr_n[1];
	assign snap.h2    = hdr_n[2];
	assign snap.h3    = hdr_n[3];
	assign snap.acc   = acc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			acc_q   <= '0;
		end else if (step) begin
			count_q <= last_byte ? '0 : count_n;
			acc_q   <= last_byte ? '0 : acc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_hdr)
			hdr_q[count_q[1:0]] <= data_byte;
	end

endmodule

// ----- design/iufc_judge.sv -----
// End-of-PDU evaluation: CRC-10 flush, header CRC-6 and status priority.
// Depends on iufc_pkg.
module iufc_judge (
	input  iufc_pkg::pdu_snap_t   snap,
	input  logic                  want_data,
	input  logic                  want_ctrl,
	output iufc_pkg::pdu_result_t res
);
	import iufc_pkg::*;

	logic [KIND_W-1:0] kind;
	logic [HCRC_W-1:0] hcrc;
	logic [PCRC_W-1:0] pcrc;
	logic [HCRC_W-1:0] peer_h;
	logic [PCRC_W-1:0] peer_p;
	logic              is_data;
	logic              is_ctrl;

	assign kind    = snap.h0[7:4];
	assign hcrc    = crc6_of(snap.h0, snap.h1);
	assign pcrc    = crc10_mod({snap.acc, 10'h000});   // flush with ten zero bits
	assign peer_h  = snap.h2[7:2];
	assign peer_p  = {snap.h2[1:0], snap.h3};
	assign is_data = (kind == KIND_DATA);
	assign is_ctrl = (kind == KIND_CTRL);

	always_comb begin
		res.kind = kind;
		res.hcrc = hcrc;
		res.pcrc = pcrc;
		priority if (snap.count < MIN_LEN)
			res.status = ST_TOO_SHORT;
		else if (is_data && !want_data)
			res.status = ST_IGNORED;
		else if (is_ctrl && !want_ctrl)
			res.status = ST_IGNORED;
		else if (is_ctrl && snap.count < MIN_LEN_CTRL)
			res.status = ST_TOO_SHORT;
		else if (!is_data && !is_ctrl)
			res.status = ST_BAD_KIND;
		else if (hcrc != peer_h)
			res.status = ST_HDR_CRC;
		else if (pcrc != peer_p)
			res.status = ST_PAYLD_CRC;
		else
			res.status = is_data ? ST_DATA_OK : ST_CTRL_OK;
	end

endmodule

// ----- test/iufc_crc_math_pkg.sv -----
// CRC arithmetic used by the IuUP checker testbench: header CRC-6 and payload CRC-10.
// No dependencies; imported by the result checker and the test top.
`timescale 1ns / 100ps

package iufc_crc_math_pkg;

	// CRC-6 over two header bytes by long division, poly 0x6f, zero start
	function automatic logic [5:0] crc6_by_division(input logic [7:0] first,
	                                                input logic [7:0] second);
		logic [21:0] rem;
		rem = {first, second, 6'b0};
		for (int k = 21; k >= 6; k--) begin
			if (rem[k])
				rem[k -: 7] = rem[k -: 7] ^ 7'h6f;
		end
		return rem[5:0];
	endfunction

	// 20-bit value modulo the CRC-10 poly 0x633
	function automatic logic [9:0] crc10_rem(input logic [19:0] v);
		logic [19:0] rem;
		rem = v;
		for (int k = 19; k >= 10; k--) begin
			if (rem[k])
				rem[k -: 11] = rem[k -: 11] ^ 11'h633;
		end
		return rem[9:0];
	endfunction

	// one payload byte into the running accumulator
	function automatic logic [9:0] crc10_feed(input logic [9:0] acc, input logic [7:0] b);
		return {acc[1:0], 8'h00} ^ crc10_rem({2'b00, acc[9:2], 10'b0}) ^ {2'b00, b};
	endfunction

	// final flush of ten zero bits
	function automatic logic [9:0] crc10_flush(input logic [9:0] acc);
		return crc10_rem({acc, 10'b0});
	endfunction

endpackage

// ----- test/iufc_result_check.sv -----
// Passive checker for the IuUP frame CRC checker: tracks config writes and PDU bytes,
// predicts each PDU result and compares it with the result stream.
// Needs iufc_pkg, iufc_crc_math_pkg.
`timescale 1ns / 100ps

module iufc_result_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [iufc_pkg::BYTE_W-1:0] s_tdata,
	input  logic                        s_tlast,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [iufc_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic                        cfg_data,
	output int unsigned                 fail_count,
	output int unsigned                 pending,
	output int unsigned                 results_seen
);
	import iufc_pkg::*;
	import iufc_crc_math_pkg::*;

	pdu_result_t         verdicts_due[$];
	logic                want_data;
	logic                want_ctrl;
	logic [COUNT_W-1:0]  seen;
	logic [BYTE_W-1:0]   hdr[HDR_LEN];
	logic [PCRC_W-1:0]   acc;

	always @(posedge clk or negedge arst_n) begin : track
		pdu_result_t        want;
		pdu_result_t        got;
		logic [STATUS_W-1:0] st;
		logic               bad;
		if (!arst_n) begin
			verdicts_due.delete();
			want_data    = 1'b1;
			want_ctrl    = 1'b1;
			seen         = '0;
			acc          = '0;
			foreach (hdr[k]) hdr[k] = '0;
			fail_count   = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WANT_DATA)
					want_data = cfg_data;
				else
					want_ctrl = cfg_data;
			end

			// results first: a result can never belong to a byte of this same edge
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(pdu_result_t)-1:0];
				results_seen++;
				if (verdicts_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] result with none expected: status %0d kind %0d",
						         $realtime, got.status, got.kind);
				end else begin
					want = verdicts_due.pop_front();
					bad  = (got.status !== want.status) || (got.kind !== want.kind)
					    || (got.hcrc !== want.hcrc) || (got.pcrc !== want.pcrc)
					    || (m_tdata[OUT_W-1] !== 1'b0);
					if (bad) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("[%0t] mismatch: exp status %0d kind %0d hcrc %02h pcrc %03h",
							       $realtime, want.status, want.kind, want.hcrc, want.pcrc);
							$display(" / got status %0d kind %0d hcrc %02h pcrc %03h pad %b",
							         got.status, got.kind, got.hcrc, got.pcrc,
							         m_tdata[OUT_W-1]);
						end
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (seen < HDR_LEN)
					hdr[seen[1:0]] = s_tdata;
				else
					acc = crc10_feed(acc, s_tdata);
				if (seen != COUNT_MAX)
					seen = seen + 1'b1;

				if (s_tlast) begin
					want.kind = hdr[0][7:4];
					want.hcrc = crc6_by_division(hdr[0], hdr[1]);
					want.pcrc = crc10_flush(acc);
					// first failing check wins
					if (seen < MIN_LEN)
						st = ST_TOO_SHORT;
					else if (want.kind == KIND_DATA && !want_data)
						st = ST_IGNORED;
					else if (want.kind == KIND_CTRL && !want_ctrl)
						st = ST_IGNORED;
					else if (want.kind == KIND_CTRL && seen < MIN_LEN_CTRL)
						st = ST_TOO_SHORT;
					else if (want.kind != KIND_DATA && want.kind != KIND_CTRL)
						st = ST_BAD_KIND;
					else if (want.hcrc != hdr[2][7:2])
						st = ST_HDR_CRC;
					else if (want.pcrc != {hdr[2][1:0], hdr[3]})
						st = ST_PAYLD_CRC;
					else
						st = (want.kind == KIND_DATA) ? ST_DATA_OK : ST_CTRL_OK;
					want.status = st;
					verdicts_due.push_back(want);
					seen = '0;
					acc  = '0;
					foreach (hdr[k]) hdr[k] = '0;
				end
			end
		end
		pending = verdicts_due.size();
	end

endmodule

// ----- test/iuup_frame_crc_checker_test.sv -----
// Test top for the IuUP frame CRC checker: clock, reset, PDU and config stimulus,
// result-side stalls and the verdict. Needs iufc_pkg, iufc_crc_math_pkg, iufc_result_check.
`timescale 1ns / 100ps

module iuup_frame_crc_checker_test;
	import iufc_pkg::*;
	import iufc_crc_math_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned LONG_HOLD    = 100;   // cycles of held-off result side
	localparam int unsigned PHASE_BYTES  = 125;

	// how a PDU is built
	localparam int FORM_GOOD  = 0;   // correct header and payload CRCs
	localparam int FORM_FLIP  = 1;   // good PDU with one bit flipped somewhere
	localparam int FORM_NOISE = 2;   // random bytes only

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata;    // [7:0] data_byte
	logic                s_tlast;    // last_byte
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;    // [2:0] status, [6:3] pdu_kind, [12:7] header crc,
	                                 // [22:13] payload crc, [23] zero
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic                cfg_data;

	int unsigned         fail_count;
	int unsigned         pending;
	int unsigned         results_seen;

	int unsigned         cycles;
	int unsigned         hold_asked;
	int unsigned         bytes_sent;
	int unsigned         pdus_sent;
	int unsigned         settings_used;
	int unsigned         burst_left;
	bit                  steady;      // sender never idles while set
	logic [BYTE_W-1:0]   pdu_bytes[$];

	iuup_frame_crc_checker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	iufc_result_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("[%0t] timeout after %0d cycles, %0d results outstanding",
				         $realtime, cycles, pending);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Result side stalls. The mode is redrawn at random: always ready,
	// coin flip, a fixed 4-of-5 pattern, or mostly stalled. A hold request from
	// the stimulus blocks m_tready for a long hold, whose length is counted here.
	initial begin : result_sink
		int unsigned hold_served;
		int unsigned mode;
		int unsigned mode_left;
		int unsigned tick;
		hold_served = 0;
		mode_left   = 0;
		mode        = 0;
		tick        = 0;
		m_tready    = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_asked) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_served++;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			tick++;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (tick % 5) != 4;
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// One byte transfer. Bursts of random length, then a random gap (possibly none)
	// unless the sender is in a steady stretch. Returns at the falling edge after the transfer.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_pdu();
		foreach (pdu_bytes[i])
			send_byte(pdu_bytes[i], i == pdu_bytes.size() - 1);
		pdus_sent++;
	endtask

	// Fill pdu_bytes. Good and flipped PDUs carry the type nibble and, from four
	// bytes on, header CRC-6 in byte 2 [7:2] and payload CRC-10 in byte 2 [1:0] and byte 3.
	task automatic build_pdu(input int unsigned len, input logic [KIND_W-1:0] kind,
	                         input int form);
		logic [PCRC_W-1:0] acc;
		logic [PCRC_W-1:0] pcrc;
		logic [HCRC_W-1:0] hcrc;
		int unsigned       pos;
		pdu_bytes.delete();
		for (int i = 0; i < len; i++)
			pdu_bytes.push_back(BYTE_W'($urandom));
		if (form != FORM_NOISE) begin
			pdu_bytes[0][7:4] = kind;
			if (len >= HDR_LEN) begin
				hcrc = crc6_by_division(pdu_bytes[0], pdu_bytes[1]);
				acc  = '0;
				for (int i = HDR_LEN; i < len; i++)
					acc = crc10_feed(acc, pdu_bytes[i]);
				pcrc = crc10_flush(acc);
				pdu_bytes[2] = {hcrc, pcrc[9:8]};
				pdu_bytes[3] = pcrc[7:0];
			end
			if (form == FORM_FLIP) begin
				pos = $urandom_range(0, len * BYTE_W - 1);
				pdu_bytes[pos / BYTE_W][pos % BYTE_W] = ~pdu_bytes[pos / BYTE_W][pos % BYTE_W];
			end
		end
	endtask

	// Stop sending, wait for every outstanding result, then let the pipeline drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// only called with the block idle
	task automatic apply_setting(input logic data_on, input logic ctrl_on);
		write_reg(CFG_WANT_DATA, data_on);
		write_reg(CFG_WANT_CTRL, ctrl_on);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Random PDUs: mostly well-formed data/control with random content, some with
	// a single flipped bit, some pure noise. Lengths mostly 4..9, a few short or long.
	task automatic random_phase(input int unsigned budget);
		int unsigned start;
		int unsigned r;
		int unsigned len;
		int          form;
		logic [KIND_W-1:0] kind;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				len = $urandom_range(1, 3);
			else if (r < 16)
				len = $urandom_range(4, 9);
			else if (r < 19)
				len = $urandom_range(10, 24);
			else
				len = $urandom_range(25, 40);
			r = $urandom_range(0, 19);
			kind = (r < 9) ? KIND_DATA : (r < 18) ? KIND_CTRL : KIND_W'($urandom);
			r = $urandom_range(0, 19);
			form = (r < 12) ? FORM_GOOD : (r < 17) ? FORM_FLIP : FORM_NOISE;
			if ($urandom_range(0, 15) == 0)
				steady = ~steady;
			build_pdu(len, kind, form);
			send_pdu();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = 1'b0;
		cfg_data      = 1'b0;
		hold_asked    = 0;
		bytes_sent    = 0;
		pdus_sent     = 0;
		settings_used = 0;
		burst_left    = 0;
		steady        = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: both types wanted
		apply_setting(1'b1, 1'b1);
		pdu_bytes = {8'hff};                        // single byte, too short
		send_pdu();
		pdu_bytes = {8'h00, 8'hff, 8'h00};          // three bytes, too short
		send_pdu();
		build_pdu(4, KIND_CTRL, FORM_GOOD);         // control needs five bytes
		send_pdu();
		build_pdu(4, KIND_DATA, FORM_GOOD);         // data with empty payload
		send_pdu();
		build_pdu(5, KIND_CTRL, FORM_GOOD);         // control ok
		send_pdu();
		build_pdu(4, 4'hf, FORM_GOOD);              // unknown type
		send_pdu();
		build_pdu(4, KIND_DATA, FORM_GOOD);         // header CRC broken
		pdu_bytes[2] = pdu_bytes[2] ^ 8'h80;
		send_pdu();
		build_pdu(4, KIND_DATA, FORM_GOOD);         // payload CRC broken
		pdu_bytes[3] = pdu_bytes[3] ^ 8'h01;
		send_pdu();
		settle();

		// random phases over all four settings, extremes included
		apply_setting(1'b0, 1'b1);
		random_phase(PHASE_BYTES);
		settle();
		apply_setting(1'b1, 1'b0);
		random_phase(PHASE_BYTES);
		settle();
		apply_setting(1'b0, 1'b0);
		random_phase(PHASE_BYTES);
		settle();
		apply_setting(1'b1, 1'b1);
		random_phase(PHASE_BYTES / 2);
		settle();                                   // sender waits for every result mid-phase
		random_phase(PHASE_BYTES / 2);

		// long result-side hold while one-byte PDUs keep coming: the result
		// register and input register fill and s_tready must drop
		hold_asked++;
		steady = 1'b1;
		repeat (12) begin
			build_pdu(1, KIND_DATA, FORM_NOISE);
			send_pdu();
		end
		steady = 1'b0;
		random_phase(PHASE_BYTES);
		settle();

		$display("Covered %0d bytes in %0d PDUs under %0d register settings,",
		         bytes_sent, pdus_sent, settings_used);
		$display("with a %0d-cycle result hold; %0d results compared, %0d failures.",
		         LONG_HOLD, results_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
